/* design/micc_pkg.sv */
// ----------------------------------------------------------------------------
// micc_pkg
// Shared constants, codes and types for the multiset intersection count table.
// ----------------------------------------------------------------------------
`default_nettype none

package micc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int COUNT_BITS    = 16;
    localparam int VALUE_BITS    = 32;
    localparam int STATUS_BITS   = 2;

    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PROBE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_LOADED    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_MATCHED   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNMATCHED = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                         kind;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } tbl_req_t;

endpackage

`default_nettype wire

/* design/multiset_intersection_count_table.sv */
// ----------------------------------------------------------------------------
// multiset_intersection_count_table
// Multiset intersection through a fully associative counting table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind, value and last. A load
//   (kind 0) raises the count of value in a 64-entry associative table; a
//   probe (kind 1) reports matched and decrements when the count is non-zero.
//   An item with last set clears the whole table after it is processed.
//   Output channel (out_valid/out_ready) returns one transaction per item:
//   result_value echoes the value, status is loaded, matched, not matched or
//   table full (value dropped).
//   An accepted item passes the input queue, then the table stage writes the result register and out_valid rises.
//   Throughput: one item per cycle while out_ready is high; the table stage
//   looks up and updates the count in the same cycle, reads the queue head
//   and writes the result register, behind a two-entry input queue.
//   Reset clears every valid bit and count at once; no clearing pass.
//   When the receiver stalls, the result register holds, the table stage
//   stops, and the queue takes up to two more items before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_intersection_count_table (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                kind,
    input  wire logic signed [micc_pkg::VALUE_BITS-1:0] value,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [micc_pkg::VALUE_BITS-1:0]   result_value,
    output logic [micc_pkg::STATUS_BITS-1:0]         status
);
    import micc_pkg::*;

    item_t                  in_item;
    item_t                  head_item;
    tbl_req_t               req;
    logic                   head_valid;
    logic                   pop;
    logic [STATUS_BITS-1:0] table_status;

    assign in_item.kind  = kind;
    assign in_item.value = value;
    assign in_item.last  = last;

    micc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    micc_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .status (table_status)
    );

    micc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .req          (req),
        .table_status (table_status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status)
    );

endmodule

`default_nettype wire

/* design/micc_front.sv */
// ----------------------------------------------------------------------------
// micc_front
// Input side: accepts items into a short queue that decouples the table stage.
// ----------------------------------------------------------------------------
`default_nettype none

module micc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire micc_pkg::item_t in_item,
    output logic                head_valid,
    output micc_pkg::item_t     head_item,
    input  wire logic           pop
);
    import micc_pkg::*;

    item_t                    slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     push;
    logic                     do_pop;

    assign in_ready   = (cnt_reg != FIFO_CNT_BITS'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(1);
        end
        if (push && !do_pop)
            cnt_next = cnt_reg + FIFO_CNT_BITS'(1);
        else if (!push && do_pop)
            cnt_next = cnt_reg - FIFO_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |=> cnt_reg == $past(cnt_reg) + FIFO_CNT_BITS'(1))
        else $error("queue count missed a push");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* design/micc_table.sv */
// ----------------------------------------------------------------------------
// micc_table
// Fully associative key/count table built as a row of cells with a shared
// lookup; classifies one request and updates the cells in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module micc_table (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire micc_pkg::tbl_req_t                 req,
    output logic [micc_pkg::STATUS_BITS-1:0]        status
);
    import micc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [VALUE_BITS-1:0]    key_reg   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]    count_reg [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]    count_next[TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [COUNT_BITS-1:0]    hit_count;
    logic [VALUE_BITS-1:0]    req_key;
    logic                     hit;
    logic                     full;
    logic                     is_load;
    logic                     is_probe;

    assign req_key  = $unsigned(req.item.value);
    assign is_load  = req.valid && (req.item.kind == KIND_LOAD);
    assign is_probe = req.valid && (req.item.kind == KIND_PROBE);

    always_comb
    begin
        hit_count = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req_key);
            hit_count    = hit_count | (match_vec[i] ? count_reg[i] : '0);
        end
    end

    assign hit  = |match_vec;
    assign full = &valid_reg;
    // lowest clear bit of the valid vector
    assign free_oh = ~valid_reg & (valid_reg + TABLE_ENTRIES'(1));

    always_comb
    begin
        if (req.item.kind == KIND_LOAD)
        begin
            if (!hit && full)
                status = ST_FULL;
            else
                status = ST_LOADED;
        end
        else
        begin
            if (hit && (hit_count != '0))
                status = ST_MATCHED;
            else
                status = ST_UNMATCHED;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            count_next[i] = count_reg[i];
            if (is_load && match_vec[i] && (count_reg[i] != COUNT_MAX))
                count_next[i] = count_reg[i] + COUNT_BITS'(1);
            else if (is_load && !hit && free_oh[i])
            begin
                count_next[i] = COUNT_BITS'(1);
                valid_next[i] = 1'b1;
            end
            else if (is_probe && match_vec[i] && (count_reg[i] != '0))
                count_next[i] = count_reg[i] - COUNT_BITS'(1);
            // clear after the item is done
            if (req.valid && req.item.last)
            begin
                count_next[i] = '0;
                valid_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                count_reg[i] <= count_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (is_load && !hit && free_oh[i])
                key_reg[i] <= req_key;
        end
    end

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key held in more than one entry");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.item.last |=> valid_reg == '0)
        else $error("table not cleared after last item");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && status == ST_FULL |-> full && !hit)
        else $error("full status with room or a hit");

    a_load_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
        is_load && !req.item.last && status == ST_LOADED |=> valid_reg != '0)
        else $error("loaded key left no valid entry");

endmodule

`default_nettype wire

/* design/micc_back.sv */
// ----------------------------------------------------------------------------
// micc_back
// Output side: pops the queue head into the table and holds the result in an
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module micc_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                head_valid,
    input  wire micc_pkg::item_t                     head_item,
    output logic                                     pop,
    output micc_pkg::tbl_req_t                       req,
    input  wire logic [micc_pkg::STATUS_BITS-1:0]    table_status,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [micc_pkg::VALUE_BITS-1:0]   result_value,
    output logic [micc_pkg::STATUS_BITS-1:0]         status
);
    import micc_pkg::*;

    logic                         out_valid_reg, out_valid_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [STATUS_BITS-1:0]       status_reg;

    // advance when the output slot is empty or being drained
    assign pop        = head_valid && (!out_valid_reg || out_ready);
    assign req.valid  = pop;
    assign req.item   = head_item;

    assign out_valid_next = pop || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg  <= head_item.value;
            status_reg <= table_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(value_reg)
            && $stable(status_reg))
        else $error("result changed while stalled");

    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !pop)
        else $error("table advanced over a pending result");

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped item produced no result");

endmodule

`default_nettype wire

/* tb/multiset_intersection_count_table_test.sv */
// ----------------------------------------------------------------------------
// multiset_intersection_count_table_test
// Self-checking bench for the multiset intersection count table. A queue of
// load and probe transactions feeds a clocked driver; a clocked monitor checks
// every result in order against an in-bench model of the counting table.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_intersection_count_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import micc_pkg::*;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [STATUS_BITS-1:0]       status;
    } outcome_t;

    localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_ready;
    logic                         kind         = KIND_LOAD;
    logic signed [VALUE_BITS-1:0] value        = '0;
    logic                         last         = 1'b0;
    logic                         out_valid;
    logic                         out_ready    = 1'b0;
    logic signed [VALUE_BITS-1:0] result_value;
    logic [STATUS_BITS-1:0]       status;

    // Shadow copy of the counting table
    logic [VALUE_BITS-1:0] tbl_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] tbl_count [TABLE_ENTRIES];
    logic                  tbl_used  [TABLE_ENTRIES];

    item_t    item_feed[$];
    outcome_t pending_results[$];

    logic [VALUE_BITS-1:0] corner_value [5] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};

    int mismatches  = 0;
    int n_checked   = 0;
    int n_loaded    = 0;
    int n_matched   = 0;
    int n_unmatched = 0;
    int n_dropped   = 0;
    int n_saturated = 0;
    int n_clears    = 0;
    int cycle_count = 0;
    logic quiet;

    multiset_intersection_count_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // No idling on either side inside this window
    assign quiet = (cycle_count >= 800) && (cycle_count < 1600);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [STATUS_BITS-1:0] count_table_step(
        logic k, logic [VALUE_BITS-1:0] v, logic lst);
        int hit;
        int slot;
        logic [STATUS_BITS-1:0] st;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && tbl_used[i] && tbl_key[i] == v)
                hit = i;
            if (slot < 0 && !tbl_used[i])
                slot = i;
        end
        if (k == KIND_LOAD)
        begin
            if (hit >= 0)
            begin
                if (tbl_count[hit] != COUNT_CEIL)
                    tbl_count[hit] = tbl_count[hit] + COUNT_BITS'(1);
                else
                    n_saturated++;
                st = ST_LOADED;
            end
            else if (slot >= 0)
            begin
                tbl_used[slot]  = 1'b1;
                tbl_key[slot]   = v;
                tbl_count[slot] = COUNT_BITS'(1);
                st = ST_LOADED;
            end
            else
                st = ST_FULL;
        end
        else if (hit >= 0 && tbl_count[hit] != '0)
        begin
            tbl_count[hit] = tbl_count[hit] - COUNT_BITS'(1);
            st = ST_MATCHED;
        end
        else
            st = ST_UNMATCHED;

        case (st)
            ST_LOADED:    n_loaded++;
            ST_MATCHED:   n_matched++;
            ST_UNMATCHED: n_unmatched++;
            default:      n_dropped++;
        endcase

        if (lst)
        begin
            n_clears++;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_used[i]  = 1'b0;
                tbl_count[i] = '0;
            end
        end
        return st;
    endfunction

    // Driver: predict on acceptance, then present the next queued transaction
    always @(posedge clk or negedge rst_n)
    begin : drive
        item_t nxt_item;
        outcome_t predicted;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= KIND_LOAD;
            value    <= '0;
            last     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted.value  = value;
                predicted.status = count_table_step(kind, value, last);
                pending_results.insert(pending_results.size(), predicted);
            end
            if (!in_valid || in_ready)
            begin
                if (item_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= 25))
                begin
                    nxt_item = item_feed.pop_front();
                    in_valid <= 1'b1;
                    kind     <= nxt_item.kind;
                    value    <= nxt_item.value;
                    last     <= nxt_item.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : observe
        outcome_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: result_value %0d status %0d",
                           result_value, status);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               want.value, result_value);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 25);
        end
    end

    task automatic add_item(logic k, logic [VALUE_BITS-1:0] v, logic lst);
        item_t it;
        it.kind  = k;
        it.value = v;
        it.last  = lst;
        item_feed.insert(item_feed.size(), it);
    endtask

    initial
    begin
        logic [VALUE_BITS-1:0] pool[$];
        logic [VALUE_BITS-1:0] base;
        logic [VALUE_BITS-1:0] v;
        int random_items;
        int pool_size;
        int n_loads;
        int n_probes;
        logic wide;
        logic close_round;

        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_count[i] = '0;
            tbl_key[i]   = '0;
        end

        // Directed: extremes, repeat loads, counts running down to zero and back
        add_item(KIND_LOAD,  32'h7FFF_FFFF, 1'b0);
        add_item(KIND_LOAD,  32'h8000_0000, 1'b0);
        add_item(KIND_LOAD,  32'h0000_0000, 1'b0);
        add_item(KIND_LOAD,  32'hFFFF_FFFF, 1'b0);
        add_item(KIND_LOAD,  32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PROBE, 32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PROBE, 32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PROBE, 32'h7FFF_FFFF, 1'b0);
        add_item(KIND_LOAD,  32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PROBE, 32'h7FFF_FFFF, 1'b0);
        add_item(KIND_PROBE, 32'h1234_5678, 1'b0);
        add_item(KIND_PROBE, 32'h8000_0000, 1'b0);
        add_item(KIND_PROBE, 32'hFFFF_FFFF, 1'b1);
        add_item(KIND_PROBE, 32'h0000_0000, 1'b0);
        add_item(KIND_LOAD,  32'h5555_5555, 1'b0);
        add_item(KIND_LOAD,  32'hAAAA_AAAA, 1'b1);
        add_item(KIND_PROBE, 32'hAAAA_AAAA, 1'b0);
        add_item(KIND_PROBE, 32'h5555_5555, 1'b1);

        // Fill every entry, then hit the full table, including a zero-count entry
        base = $urandom();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            add_item(KIND_LOAD, base + i, 1'b0);
        add_item(KIND_LOAD,  base + TABLE_ENTRIES, 1'b0);
        add_item(KIND_LOAD,  base + 3, 1'b0);
        add_item(KIND_PROBE, base, 1'b0);
        add_item(KIND_LOAD,  base + TABLE_ENTRIES + 1, 1'b0);
        add_item(KIND_PROBE, base + TABLE_ENTRIES, 1'b0);
        add_item(KIND_PROBE, base + 3, 1'b1);

        // Build up one key with repeated loads next to a neighbor key
        v = $urandom();
        add_item(KIND_LOAD, v ^ 32'h1, 1'b0);
        for (int i = 0; i < 8; i++)
            add_item(KIND_LOAD, v, 1'b0);
        add_item(KIND_PROBE, v, 1'b0);
        add_item(KIND_LOAD,  v, 1'b0);
        add_item(KIND_LOAD,  v, 1'b0);
        add_item(KIND_PROBE, v ^ 32'h1, 1'b0);
        add_item(KIND_PROBE, v, 1'b1);

        // Random rounds: load a multiset, probe against it, mostly closed by last
        random_items = 0;
        while (random_items < 1900)
        begin
            pool.delete();
            wide      = ($urandom_range(0, 99) < 15);
            pool_size = wide ? $urandom_range(50, 72) : $urandom_range(1, 12);
            for (int i = 0; i < pool_size; i++)
                pool.insert(pool.size(), ($urandom_range(0, 7) == 0) ?
                            corner_value[$urandom_range(0, 4)] : $urandom());
            n_loads = wide ? pool_size + $urandom_range(0, 10)
                           : pool_size * $urandom_range(1, 3);
            for (int i = 0; i < n_loads; i++)
                add_item(KIND_LOAD, pool[$urandom_range(0, pool_size - 1)],
                         $urandom_range(0, 31) == 0);
            n_probes    = $urandom_range(1, n_loads + 4);
            close_round = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < n_probes; i++)
            begin
                v = ($urandom_range(0, 4) == 0) ? $urandom()
                                                : pool[$urandom_range(0, pool_size - 1)];
                add_item(KIND_PROBE, v, close_round && (i == n_probes - 1));
            end
            if ($urandom_range(0, 9) == 0)
                add_item(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
            random_items += n_loads + n_probes;
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (item_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results: %0d loaded (%0d at the count ceiling), %0d matched,",
                 n_checked, n_loaded, n_saturated, n_matched);
        $display("%0d not matched, %0d dropped on a full table, %0d table clears",
                 n_unmatched, n_dropped, n_clears);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
